### rtl/krs_pkg.sv
package krs_pkg;

  localparam int CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic [8:0] HELD_MAX = 9'd511;

  localparam logic signed [39:0] TOTAL_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] TOTAL_MIN = 40'sh80_0000_0000;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] item_key;
    logic signed [31:0] item_price;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic [8:0]         held_count;
    logic signed [39:0] range_total;
    logic               status;
  } resp_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] price;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic found;
    logic free_found;
  } scan_flags_t;

endpackage

### rtl/krs_slot_mem.sv
module krs_slot_mem #(
  parameter int DEPTH = krs_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  krs_pkg::slot_t    wdata,
  input  logic [AW-1:0]     raddr,
  output krs_pkg::slot_t    rdata
);

  krs_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/krs_scan_unit.sv
// One slot per step: key match, first free slot, range compare and accumulate.
module krs_scan_unit #(
  parameter int AW    = 8,
  parameter int ACC_W = 41
) (
  input  logic                    clk,
  input  logic                    rst,
  input  krs_pkg::scan_ctl_t      ctl,
  input  logic [AW-1:0]           idx,
  input  krs_pkg::slot_t          slot,
  input  krs_pkg::req_t           req,
  output krs_pkg::scan_flags_t    flags,
  output logic [AW-1:0]           found_idx,
  output logic [AW-1:0]           free_idx,
  output logic signed [ACC_W-1:0] acc
);

  logic hit_key;
  logic in_rng;
  logic lookup;

  assign hit_key = slot.valid && ($signed(slot.key) == $signed(req.item_key));
  // empty interval falls out: no key can satisfy both bounds
  assign in_rng  = slot.valid && ($signed(slot.key) >= $signed(req.range_low))
                              && ($signed(slot.key) <= $signed(req.range_high));
  assign lookup  = (req.cmd == krs_pkg::CMD_INSERT) || (req.cmd == krs_pkg::CMD_DELETE);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      flags <= '0;
      acc   <= '0;
    end else if (ctl.step) begin
      if (lookup && hit_key && !flags.found) begin
        flags.found <= 1'b1;
        found_idx   <= idx;
      end
      if (lookup && !slot.valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
        free_idx         <= idx;
      end
      if ((req.cmd == krs_pkg::CMD_RANGE) && in_rng) begin
        acc <= acc + ACC_W'($signed(slot.price));
      end
    end
  end

endmodule

### rtl/keyed_store_range_sum_core.sv
// Sequence: insert, delete and range sum walk every slot in SCAN behind the registered
//   read, then commit in FINISH, which raises done; count skips the walk and goes
//   straight from IDLE to FINISH.
// Items are taken one at a time, at a pace set by the single read port of the slot
//   memory walked one slot a cycle; start is taken on the done cycle.
// Reset: synchronous rst starts a clearing pass over every slot with busy high.
// Results are shown for one cycle on done; the receiver cannot stall.
module keyed_store_range_sum_core #(
  parameter int CAPACITY = krs_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  krs_pkg::req_t  request,
  output logic           done,
  output krs_pkg::resp_t result
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int ACC_W = (33 + AW > 41) ? 33 + AW : 41;
  localparam int OW    = (CW > 9) ? CW : 9;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(krs_pkg::TOTAL_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(krs_pkg::TOTAL_MIN);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t state;

  // walk counter: one wider than the address so it can reach CAPACITY
  logic [AW:0]    cnt;
  logic [AW-1:0]  pidx;
  krs_pkg::req_t  req;
  logic [CW-1:0]  entry_total;
  logic [CW-1:0]  entry_total_next;
  logic           status_next;
  logic [8:0]     held_next;

  // slot memory ports
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  krs_pkg::slot_t  mem_wdata;
  krs_pkg::slot_t  mem_rdata;

  // scan unit
  krs_pkg::scan_ctl_t    sctl;
  krs_pkg::scan_flags_t  sflags;
  logic [AW-1:0]         found_idx;
  logic [AW-1:0]         free_idx;
  logic signed [ACC_W-1:0] acc;

  logic                    accept;
  logic signed [39:0]      total_sat;
  logic [OW-1:0]           total_ext;

  assign accept = start && !busy;
  assign busy   = (state != IDLE);

  // memory read data is registered, so step waits for cnt to pass zero and pidx trails cnt by one slot
  always_comb begin
    sctl.clear = accept;
    sctl.step  = (state == SCAN) && (cnt != '0);
  end

  krs_slot_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (mem_rdata)
  );

  krs_scan_unit #(
    .AW    (AW),
    .ACC_W (ACC_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .idx       (pidx),
    .slot      (mem_rdata),
    .req       (req),
    .flags     (sflags),
    .found_idx (found_idx),
    .free_idx  (free_idx),
    .acc       (acc)
  );

  // memory write: clearing pass, or the commit of an insert/delete
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = cnt[AW-1:0];
    mem_wdata.valid = 1'b0;
    mem_wdata.key   = req.item_key;
    mem_wdata.price = req.item_price;
    if (state == CLEAR) begin
      mem_we = 1'b1;
    end else if (state == FINISH) begin
      if (req.cmd == krs_pkg::CMD_INSERT) begin
        mem_wdata.valid = 1'b1;
        if (sflags.found) begin
          mem_we    = 1'b1;
          mem_waddr = found_idx;
        end else if (sflags.free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
        end
      end else if (req.cmd == krs_pkg::CMD_DELETE) begin
        mem_we    = sflags.found;
        mem_waddr = found_idx;
      end
    end
  end

  // clamp the wide accumulator to the 40-bit result
  always_comb begin
    if (acc > SAT_HI) begin
      total_sat = krs_pkg::TOTAL_MAX;
    end else if (acc < SAT_LO) begin
      total_sat = krs_pkg::TOTAL_MIN;
    end else begin
      total_sat = acc[39:0];
    end
  end

  // key count and status once the walk is done
  always_comb begin
    entry_total_next = entry_total;
    status_next      = krs_pkg::ST_OK;
    if (req.cmd == krs_pkg::CMD_INSERT) begin
      if (!sflags.found) begin
        if (sflags.free_found) begin
          entry_total_next = entry_total + 1'b1;
        end else begin
          status_next = krs_pkg::ST_FULL;
        end
      end
    end else if (req.cmd == krs_pkg::CMD_DELETE) begin
      if (sflags.found && (entry_total != '0)) begin
        entry_total_next = entry_total - 1'b1;
      end
    end
  end

  // held count after this item, saturated to the field width
  always_comb begin
    total_ext = OW'(entry_total_next);
    held_next = (total_ext > OW'(krs_pkg::HELD_MAX)) ? krs_pkg::HELD_MAX : total_ext[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      cnt         <= '0;
      entry_total <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        CLEAR: begin
          if (cnt[AW-1:0] == AW'(CAPACITY - 1)) begin
            state <= IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        IDLE: begin
          if (start) begin
            req <= request;
            cnt <= '0;
            // count needs no walk
            state <= (request.cmd == krs_pkg::CMD_COUNT) ? FINISH : SCAN;
          end
        end
        SCAN: begin
          pidx <= cnt[AW-1:0];
          if (cnt == (AW+1)'(CAPACITY)) begin
            state <= FINISH;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        FINISH: begin
          result.status      <= status_next;
          result.range_total <= total_sat;
          result.held_count  <= held_next;
          entry_total        <= entry_total_next;
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### rtl/krs_checker.sv
module krs_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input krs_pkg::req_t  request,
  input logic           done,
  input krs_pkg::resp_t result
);

  // a result is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted item holds the block and gives no result in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not hold busy");

  // count skips the walk and reports a zero total
  a_count_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.cmd == krs_pkg::CMD_COUNT) |=> ##1
      (done && result.range_total == '0 && result.status == krs_pkg::ST_OK))
    else $error("count item result wrong or late");

  // a dropped insert never carries a range total
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == krs_pkg::ST_FULL) |-> (result.range_total == '0))
    else $error("full status with nonzero total");

endmodule

bind keyed_store_range_sum_core krs_checker u_krs_checker (.*);
